FILE: src/sps_pkg.sv
// ----------------------------------------------------------------------------
// sps_pkg
// Shared types and constants for the SPI EEPROM page write sequencer.
// ----------------------------------------------------------------------------
package sps_pkg;

  localparam int PageBytesDef = 64;
  localparam int FifoDepthDef = 4;
  localparam int AddrW        = 5;
  localparam int DataW        = 32;

  // request types
  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_RX    = 2'd2;

  // result ops
  localparam logic [1:0] OP_SHIFT = 2'd0;
  localparam logic [1:0] OP_DESEL = 2'd1;
  localparam logic [1:0] OP_HOST  = 2'd2;
  localparam logic [1:0] OP_DONE  = 2'd3;

  // register indexes
  localparam logic [2:0] REG_POLL_LIMIT = 3'd0;
  localparam logic [2:0] REG_BUSY_MASK  = 3'd1;
  localparam logic [2:0] REG_OP_WREN    = 3'd2;
  localparam logic [2:0] REG_OP_WRITE   = 3'd3;
  localparam logic [2:0] REG_OP_READ    = 3'd4;
  localparam logic [2:0] REG_OP_RDSR    = 3'd5;

  localparam logic [23:0] POLL_LIMIT_RST = 24'd1000000;
  localparam logic [7:0]  DUMMY_BYTE     = 8'hFF;

  // result slots, emitted in ascending order
  localparam int SLOT_WREN    = 0;
  localparam int SLOT_DESEL_A = 1;
  localparam int SLOT_WRITE   = 2;
  localparam int SLOT_READ    = 3;
  localparam int SLOT_AH      = 4;
  localparam int SLOT_AL      = 5;
  localparam int SLOT_DATA    = 6;
  localparam int SLOT_HOST    = 7;
  localparam int SLOT_FF_RD   = 8;
  localparam int SLOT_DESEL_B = 9;
  localparam int SLOT_DONE    = 10;
  localparam int SLOT_RDSR    = 11;
  localparam int SLOT_FF_POLL = 12;
  localparam int SlotN        = 13;
  localparam int SlotW        = $clog2(SlotN);

  typedef struct packed {
    logic [23:0] poll_limit;
    logic [7:0]  busy_mask;
    logic [7:0]  op_write_enable;
    logic [7:0]  op_write;
    logic [7:0]  op_read;
    logic [7:0]  op_read_status;
  } cfg_t;

  typedef struct packed {
    logic [SlotN-1:0] mask;
    logic [7:0]       ah;
    logic [7:0]       al;
    logic [7:0]       dbyte;
    logic             ok;
  } cmd_t;

endpackage

FILE: src/sps_if.sv
// ----------------------------------------------------------------------------
// sps_req_if / sps_rsp_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface sps_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [15:0] start_addr;
  logic        first;
  logic        last;
  logic [7:0]  data_byte;

  modport source (output valid, req_type, start_addr, first, last, data_byte, input ready);
  modport sink   (input valid, req_type, start_addr, first, last, data_byte, output ready);
endinterface

interface sps_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] tx_byte;
  logic       capture;
  logic [7:0] host_byte;
  logic       ok;
  logic       last_of_run;

  modport source (output valid, op, tx_byte, capture, host_byte, ok, last_of_run, input ready);
  modport sink   (input valid, op, tx_byte, capture, host_byte, ok, last_of_run, output ready);
endinterface

FILE: src/sps_cfg.sv
// ----------------------------------------------------------------------------
// sps_cfg
// APB register file for poll limit, busy mask and opcodes.
// ----------------------------------------------------------------------------
module sps_cfg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [sps_pkg::AddrW-1:0] paddr,
  input  logic [sps_pkg::DataW-1:0] pwdata,
  output logic [sps_pkg::DataW-1:0] prdata,
  output logic                      pready,
  output sps_pkg::cfg_t             cfg_o
);

  sps_pkg::cfg_t cfg_q, cfg_d;
  logic [2:0]    idx;
  logic          wr;

  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      case (idx)
        sps_pkg::REG_POLL_LIMIT: cfg_d.poll_limit      = pwdata[23:0];
        sps_pkg::REG_BUSY_MASK:  cfg_d.busy_mask       = pwdata[7:0];
        sps_pkg::REG_OP_WREN:    cfg_d.op_write_enable = pwdata[7:0];
        sps_pkg::REG_OP_WRITE:   cfg_d.op_write        = pwdata[7:0];
        sps_pkg::REG_OP_READ:    cfg_d.op_read         = pwdata[7:0];
        sps_pkg::REG_OP_RDSR:    cfg_d.op_read_status  = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      sps_pkg::REG_POLL_LIMIT: prdata = {8'd0, cfg_q.poll_limit};
      sps_pkg::REG_BUSY_MASK:  prdata = {24'd0, cfg_q.busy_mask};
      sps_pkg::REG_OP_WREN:    prdata = {24'd0, cfg_q.op_write_enable};
      sps_pkg::REG_OP_WRITE:   prdata = {24'd0, cfg_q.op_write};
      sps_pkg::REG_OP_READ:    prdata = {24'd0, cfg_q.op_read};
      sps_pkg::REG_OP_RDSR:    prdata = {24'd0, cfg_q.op_read_status};
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.poll_limit      <= sps_pkg::POLL_LIMIT_RST;
      cfg_q.busy_mask       <= 8'd1;
      cfg_q.op_write_enable <= 8'd6;
      cfg_q.op_write        <= 8'd2;
      cfg_q.op_read         <= 8'd3;
      cfg_q.op_read_status  <= 8'd5;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

FILE: src/sps_front.sv
// ----------------------------------------------------------------------------
// sps_front
// Accepts requests, tracks the transfer phase and address, and turns each
// transaction into a slot mask of results for the back end.
// ----------------------------------------------------------------------------
module sps_front #(
  parameter int PAGE_BYTES = sps_pkg::PageBytesDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  sps_pkg::cfg_t cfg_i,
  sps_req_if.sink       req_i,
  input  logic          q_ready_i,
  output logic          q_push_o,
  output sps_pkg::cmd_t q_cmd_o
);

  typedef enum logic [6:0] {
    PH_IDLE     = 7'b0000001,
    PH_WOPEN    = 7'b0000010,
    PH_WBETWEEN = 7'b0000100,
    PH_POLL     = 7'b0001000,
    PH_DROP     = 7'b0010000,
    PH_ROPEN    = 7'b0100000,
    PH_RWAIT    = 7'b1000000
  } phase_e;

  phase_e        phase_q, phase_d;
  logic [15:0]   cur_q, cur_d;
  logic [23:0]   polls_q, polls_d;
  logic          ends_q, ends_d;
  logic [15:0]   base, naddr;
  logic          acc, is_wr, open_pfx, boundary;
  logic [8:0]    rem_sum;
  logic [7:0]    hi_tab [256];
  logic [7:0]    lo_tab [256];
  sps_pkg::cmd_t cmd;

  // address modulo page size, split into high and low byte remainders
  for (genvar g = 0; g < 256; g++) begin : g_rem
    localparam logic [7:0] HR = 8'((g * 256) % PAGE_BYTES);
    localparam logic [7:0] LR = 8'(g % PAGE_BYTES);
    assign hi_tab[g] = HR;
    assign lo_tab[g] = LR;
  end

  assign acc          = req_i.valid && q_ready_i;
  assign req_i.ready  = q_ready_i;
  assign base         = (phase_q == PH_IDLE && req_i.first) ? req_i.start_addr : cur_q;
  assign naddr        = base + 16'd1;
  assign rem_sum      = {1'b0, hi_tab[naddr[15:8]]} + {1'b0, lo_tab[naddr[7:0]]};
  assign boundary     = (rem_sum == 9'd0) || (rem_sum == 9'(PAGE_BYTES));

  always_comb begin
    cmd       = '0;
    cmd.ah    = base[15:8];
    cmd.al    = base[7:0];
    cmd.dbyte = req_i.data_byte;
    phase_d   = phase_q;
    cur_d     = cur_q;
    polls_d   = polls_q;
    ends_d    = ends_q;
    is_wr     = 1'b0;
    open_pfx  = 1'b0;
    case (phase_q)
      PH_IDLE: begin
        if (req_i.req_type == sps_pkg::REQ_WRITE) begin
          is_wr    = 1'b1;
          open_pfx = 1'b1;
        end else if (req_i.req_type == sps_pkg::REQ_READ) begin
          cmd.mask[sps_pkg::SLOT_READ]  = 1'b1;
          cmd.mask[sps_pkg::SLOT_AH]    = 1'b1;
          cmd.mask[sps_pkg::SLOT_AL]    = 1'b1;
          cmd.mask[sps_pkg::SLOT_FF_RD] = 1'b1;
          cur_d   = base;
          ends_d  = req_i.last;
          phase_d = PH_RWAIT;
        end
      end
      PH_WOPEN: begin
        if (req_i.req_type == sps_pkg::REQ_WRITE) is_wr = 1'b1;
      end
      PH_WBETWEEN: begin
        if (req_i.req_type == sps_pkg::REQ_WRITE) begin
          is_wr    = 1'b1;
          open_pfx = 1'b1;
        end
      end
      PH_POLL: begin
        if (req_i.req_type == sps_pkg::REQ_RX) begin
          cmd.mask[sps_pkg::SLOT_DESEL_B] = 1'b1;
          if ((req_i.data_byte & cfg_i.busy_mask) == 8'd0) begin
            cmd.mask[sps_pkg::SLOT_DONE] = 1'b1;
            cmd.ok  = 1'b1;
            phase_d = ends_q ? PH_IDLE : PH_WBETWEEN;
          end else if (polls_q == 24'd0) begin
            cmd.mask[sps_pkg::SLOT_DONE] = 1'b1;
            phase_d = ends_q ? PH_IDLE : PH_DROP;
          end else begin
            cmd.mask[sps_pkg::SLOT_RDSR]    = 1'b1;
            cmd.mask[sps_pkg::SLOT_FF_POLL] = 1'b1;
            polls_d = polls_q - 24'd1;
          end
        end
      end
      PH_DROP: begin
        if (req_i.req_type == sps_pkg::REQ_WRITE && req_i.last) phase_d = PH_IDLE;
      end
      PH_ROPEN: begin
        if (req_i.req_type == sps_pkg::REQ_READ) begin
          cmd.mask[sps_pkg::SLOT_FF_RD] = 1'b1;
          ends_d  = req_i.last;
          phase_d = PH_RWAIT;
        end
      end
      PH_RWAIT: begin
        if (req_i.req_type == sps_pkg::REQ_RX) begin
          cmd.mask[sps_pkg::SLOT_HOST] = 1'b1;
          cur_d = naddr;
          if (ends_q) begin
            cmd.mask[sps_pkg::SLOT_DESEL_B] = 1'b1;
            phase_d = PH_IDLE;
          end else begin
            phase_d = PH_ROPEN;
          end
        end
      end
      default: phase_d = PH_IDLE;
    endcase

    if (open_pfx) begin
      cmd.mask[sps_pkg::SLOT_WREN]    = 1'b1;
      cmd.mask[sps_pkg::SLOT_DESEL_A] = 1'b1;
      cmd.mask[sps_pkg::SLOT_WRITE]   = 1'b1;
      cmd.mask[sps_pkg::SLOT_AH]      = 1'b1;
      cmd.mask[sps_pkg::SLOT_AL]      = 1'b1;
    end
    if (is_wr) begin
      cmd.mask[sps_pkg::SLOT_DATA] = 1'b1;
      cur_d  = naddr;
      ends_d = req_i.last;
      if (req_i.last || boundary) begin
        cmd.mask[sps_pkg::SLOT_DESEL_B] = 1'b1;
        if (cfg_i.poll_limit == 24'd0) begin
          cmd.mask[sps_pkg::SLOT_DONE] = 1'b1;
          phase_d = req_i.last ? PH_IDLE : PH_DROP;
        end else begin
          cmd.mask[sps_pkg::SLOT_RDSR]    = 1'b1;
          cmd.mask[sps_pkg::SLOT_FF_POLL] = 1'b1;
          polls_d = cfg_i.poll_limit - 24'd1;
          phase_d = PH_POLL;
        end
      end else begin
        phase_d = PH_WOPEN;
      end
    end
  end

  assign q_push_o = acc && (cmd.mask != '0);
  assign q_cmd_o  = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cur_q   <= '0;
      polls_q <= '0;
      ends_q  <= 1'b0;
    end else if (acc) begin
      phase_q <= phase_d;
      cur_q   <= cur_d;
      polls_q <= polls_d;
      ends_q  <= ends_d;
    end
  end

endmodule

FILE: src/sps_fifo.sv
// ----------------------------------------------------------------------------
// sps_fifo
// Small command queue between front and back end.
// ----------------------------------------------------------------------------
module sps_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = sps_pkg::FifoDepthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             ready_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign ready_o = (cnt_q != CntW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) wr_d = (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + PtrW'(1);
    if (do_pop)  rd_d = (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + PtrW'(1);
    if (do_push && !do_pop) cnt_d = cnt_q + CntW'(1);
    if (!do_push && do_pop) cnt_d = cnt_q - CntW'(1);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

FILE: src/sps_back.sv
// ----------------------------------------------------------------------------
// sps_back
// Walks the slot mask of each command and drives one result per cycle
// through a registered output while the result channel is not stalled.
// ----------------------------------------------------------------------------
module sps_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  sps_pkg::cfg_t cfg_i,
  input  logic          q_valid_i,
  input  sps_pkg::cmd_t q_cmd_i,
  output logic          q_pop_o,
  sps_rsp_if.source     rsp_o
);

  sps_pkg::cmd_t              cmd_q;
  logic [sps_pkg::SlotN-1:0]  mask_q, mask_d, rest;
  logic [sps_pkg::SlotW-1:0]  idx;
  logic                       busy, emit, load;
  logic                       valid_q, valid_d;
  logic [1:0]                 op_q, op_d;
  logic [7:0]                 tx_q, tx_d, host_q, host_d;
  logic                       cap_q, cap_d, ok_q, ok_d, lor_q, lor_d;

  assign busy = (mask_q != '0);
  assign emit = busy && (!valid_q || rsp_o.ready);

  always_comb begin
    idx = '0;
    for (int i = sps_pkg::SlotN - 1; i >= 0; i--) begin
      if (mask_q[i]) idx = sps_pkg::SlotW'(i);
    end
  end

  assign rest    = mask_q & ~(sps_pkg::SlotN'(1) << idx);
  assign load    = q_valid_i && (!busy || (emit && rest == '0));
  assign q_pop_o = load;

  always_comb begin
    mask_d = mask_q;
    if (emit) mask_d = rest;
    if (load) mask_d = q_cmd_i.mask;
  end

  always_comb begin
    op_d   = sps_pkg::OP_SHIFT;
    tx_d   = '0;
    cap_d  = 1'b0;
    host_d = '0;
    ok_d   = 1'b0;
    lor_d  = (rest == '0);
    case (idx)
      sps_pkg::SlotW'(sps_pkg::SLOT_WREN):    tx_d = cfg_i.op_write_enable;
      sps_pkg::SlotW'(sps_pkg::SLOT_DESEL_A): op_d = sps_pkg::OP_DESEL;
      sps_pkg::SlotW'(sps_pkg::SLOT_WRITE):   tx_d = cfg_i.op_write;
      sps_pkg::SlotW'(sps_pkg::SLOT_READ):    tx_d = cfg_i.op_read;
      sps_pkg::SlotW'(sps_pkg::SLOT_AH):      tx_d = cmd_q.ah;
      sps_pkg::SlotW'(sps_pkg::SLOT_AL):      tx_d = cmd_q.al;
      sps_pkg::SlotW'(sps_pkg::SLOT_DATA):    tx_d = cmd_q.dbyte;
      sps_pkg::SlotW'(sps_pkg::SLOT_HOST): begin
        op_d   = sps_pkg::OP_HOST;
        host_d = cmd_q.dbyte;
      end
      sps_pkg::SlotW'(sps_pkg::SLOT_FF_RD),
      sps_pkg::SlotW'(sps_pkg::SLOT_FF_POLL): begin
        tx_d  = sps_pkg::DUMMY_BYTE;
        cap_d = 1'b1;
      end
      sps_pkg::SlotW'(sps_pkg::SLOT_DESEL_B): op_d = sps_pkg::OP_DESEL;
      sps_pkg::SlotW'(sps_pkg::SLOT_DONE): begin
        op_d = sps_pkg::OP_DONE;
        ok_d = cmd_q.ok;
      end
      sps_pkg::SlotW'(sps_pkg::SLOT_RDSR):    tx_d = cfg_i.op_read_status;
      default: ;
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    if (rsp_o.ready) valid_d = 1'b0;
    if (emit)        valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      mask_q  <= mask_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) cmd_q <= q_cmd_i;
    if (emit) begin
      op_q   <= op_d;
      tx_q   <= tx_d;
      cap_q  <= cap_d;
      host_q <= host_d;
      ok_q   <= ok_d;
      lor_q  <= lor_d;
    end
  end

  assign rsp_o.valid       = valid_q;
  assign rsp_o.op          = op_q;
  assign rsp_o.tx_byte     = tx_q;
  assign rsp_o.capture     = cap_q;
  assign rsp_o.host_byte   = host_q;
  assign rsp_o.ok          = ok_q;
  assign rsp_o.last_of_run = lor_q;

endmodule

FILE: src/spi_eeprom_page_write_sequencer.sv
// ----------------------------------------------------------------------------
// spi_eeprom_page_write_sequencer
// 25xx-style SPI EEPROM sequencer: page writes with status polling and
// sequential reads, driven as a stream of SPI frame actions.
// Each request passes through the command queue and the back end slot mask,
// and results leave through a registered output. The back end gives one
// result per cycle unless the result channel stalls, and 0 to 9 per request.
// The front end takes one request per cycle while the command queue has room.
// Reset: asynchronous, clears phase, address, poll count and queue;
// registers return to their documented defaults.
// ----------------------------------------------------------------------------
module spi_eeprom_page_write_sequencer #(
  parameter int PAGE_BYTES = sps_pkg::PageBytesDef,
  parameter int FIFO_DEPTH = sps_pkg::FifoDepthDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  sps_req_if.sink                   req_i,
  sps_rsp_if.source                 rsp_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [sps_pkg::AddrW-1:0] paddr,
  input  logic [sps_pkg::DataW-1:0] pwdata,
  output logic [sps_pkg::DataW-1:0] prdata,
  output logic                      pready
);

  localparam int CmdW = $bits(sps_pkg::cmd_t);

  sps_pkg::cfg_t cfg;
  sps_pkg::cmd_t push_cmd, pop_cmd;
  logic          push, q_ready, q_valid, pop;
  logic [CmdW-1:0] pop_raw;

  sps_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o(cfg)
  );

  sps_front #(.PAGE_BYTES(PAGE_BYTES)) u_front (
    .clk_i, .rst_ni, .cfg_i(cfg), .req_i,
    .q_ready_i(q_ready), .q_push_o(push), .q_cmd_o(push_cmd)
  );

  sps_fifo #(.WIDTH(CmdW), .DEPTH(FIFO_DEPTH)) u_fifo (
    .clk_i, .rst_ni,
    .push_i(push), .data_i(push_cmd), .ready_o(q_ready),
    .pop_i(pop), .valid_o(q_valid), .data_o(pop_raw)
  );

  assign pop_cmd = pop_raw;

  sps_back u_back (
    .clk_i, .rst_ni, .cfg_i(cfg),
    .q_valid_i(q_valid), .q_cmd_i(pop_cmd), .q_pop_o(pop), .rsp_o
  );

endmodule

FILE: src/sps_checker.sv
// ----------------------------------------------------------------------------
// sps_checker
// Port-level checks on the result channel and configuration port.
// ----------------------------------------------------------------------------
module sps_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [1:0] rsp_op,
  input logic [7:0] rsp_tx_byte,
  input logic       rsp_capture,
  input logic [7:0] rsp_host_byte,
  input logic       rsp_ok,
  input logic       rsp_last,
  input logic       pready
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_op) && $stable(rsp_tx_byte)
      && $stable(rsp_host_byte) && $stable(rsp_last))
    else $error("result changed while stalled");

  a_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && rsp_capture |-> rsp_op == sps_pkg::OP_SHIFT && rsp_tx_byte == 8'hFF)
    else $error("capture on a non-dummy shift");

  a_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> (rsp_op == sps_pkg::OP_SHIFT || rsp_tx_byte == 8'd0)
      && (rsp_op == sps_pkg::OP_HOST || rsp_host_byte == 8'd0)
      && (rsp_op == sps_pkg::OP_DONE || !rsp_ok))
    else $error("field set for wrong op");

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && rsp_op == sps_pkg::OP_DONE |-> rsp_last)
    else $error("write done not last of run");

  a_pready: assert property (@(posedge clk_i) pready)
    else $error("pready low");

endmodule

bind spi_eeprom_page_write_sequencer sps_checker u_sps_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .rsp_valid     (rsp_o.valid),
  .rsp_ready     (rsp_o.ready),
  .rsp_op        (rsp_o.op),
  .rsp_tx_byte   (rsp_o.tx_byte),
  .rsp_capture   (rsp_o.capture),
  .rsp_host_byte (rsp_o.host_byte),
  .rsp_ok        (rsp_o.ok),
  .rsp_last      (rsp_o.last_of_run),
  .pready        (pready)
);
